/* src/csse_pkg.sv */
// Package of the cubic spline segment evaluator: widths, item types,
// basis select codes and the doubled basis coefficient table.
// No dependencies.
`default_nettype none

package csse_pkg;

  localparam int COORD_BITS      = 32;
  localparam int PARAM_FRAC_BITS = 16;

  // t is Q0.F with one extra bit so that exactly 1.0 fits
  localparam int T_BITS   = PARAM_FRAC_BITS + 1;
  localparam int SQ_BITS  = 2 * T_BITS;
  // doubled weights reach 24 * 2^F in magnitude at most
  localparam int W_BITS   = PARAM_FRAC_BITS + 6;
  localparam int P_BITS   = COORD_BITS + W_BITS;
  localparam int SUM_BITS = P_BITS + 2;
  // weights carry F+1 fraction bits, i.e. T_BITS of them
  localparam int R_BITS   = SUM_BITS - T_BITS;
  localparam int N_STAGES = 7;
  localparam int N_ROWS   = 4;
  localparam int N_POWERS = 4;
  localparam int N_KINDS  = 3;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic        [T_BITS-1:0]     param_t;
  typedef logic        [SQ_BITS-1:0]    square_t;
  typedef logic signed [W_BITS-1:0]     weight_t;
  typedef logic signed [P_BITS-1:0]     prod_t;
  typedef logic signed [SUM_BITS-1:0]   sum_t;
  typedef logic signed [R_BITS-1:0]     res_t;
  typedef logic signed [4:0]            coef_t;

  typedef enum logic [1:0] {
    KIND_BEZIER      = 2'd0,
    KIND_HERMITE     = 2'd1,
    KIND_CATMULL_ROM = 2'd2
  } kind_e;

  // code with no basis behind it: a write of it is dropped
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  localparam param_t  T_ONE      = param_t'(1) << PARAM_FRAC_BITS;
  localparam square_t SQ_HALF    = square_t'(1) << (PARAM_FRAC_BITS - 1);
  localparam sum_t    ROUND_HALF = sum_t'(1) << PARAM_FRAC_BITS;
  localparam coord_t  COORD_MAX  = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam coord_t  COORD_MIN  = {1'b1, {(COORD_BITS-1){1'b0}}};

  typedef struct packed {
    param_t t_param;
    coord_t start_value;
    coord_t end_value;
    coord_t first_control;
    coord_t second_control;
  } in_item_t;

  typedef struct packed {
    coord_t curve_value;
    logic   clipped;
  } out_item_t;

  // [kind][value row][t^3, t^2, t, 1], coefficients doubled
  localparam coef_t BASIS_TAB [N_KINDS][N_ROWS][N_POWERS] = '{
    '{ '{-5'sd2,  5'sd6,  -5'sd6, 5'sd2}, '{ 5'sd2,  5'sd0, 5'sd0, 5'sd0},
       '{ 5'sd6, -5'sd12,  5'sd6, 5'sd0}, '{-5'sd6,  5'sd6, 5'sd0, 5'sd0} },
    '{ '{ 5'sd4, -5'sd6,   5'sd0, 5'sd2}, '{-5'sd4,  5'sd6, 5'sd0, 5'sd0},
       '{ 5'sd2, -5'sd4,   5'sd2, 5'sd0}, '{ 5'sd2, -5'sd2, 5'sd0, 5'sd0} },
    '{ '{-5'sd1,  5'sd2,  -5'sd1, 5'sd0}, '{ 5'sd3, -5'sd5, 5'sd0, 5'sd2},
       '{-5'sd3,  5'sd4,   5'sd1, 5'sd0}, '{ 5'sd1, -5'sd1, 5'sd0, 5'sd0} }
  };

endpackage

`default_nettype wire

/* src/cubic_spline_segment_eval.sv */
// Cubic spline segment evaluator, one axis, seven-stage pipeline.
// Depends on csse_pkg for widths, item types and the basis table.
//
// Usage:
//   Input channel in_valid_i / in_ready_o carries one item: t_param
//   (unsigned Q1.16, values above 1.0 act as 1.0) and the four segment
//   values in signed Q16.16. Output channel out_valid_o / out_ready_i
//   returns curve_value, rounded half up and saturated, with clipped set
//   when saturation took place.
//   The basis is picked by cfg_we_i / cfg_wdata_i: 0 Bezier, 1 Hermite,
//   2 Catmull-Rom; a write of 3 is dropped. Write it only while idle.
// Timing:
//   Seven register stages: t squared, t cubed product, t cubed rounding, basis
//   weights, value-by-weight products, pair sums, final sum and saturation.
//   Throughput is one item per cycle while the receiver does not stall.
// Reset and stall:
//   Reset empties the pipeline and selects Bezier. When the receiver
//   stalls, each stage holds only while the one after it is full, so
//   bubbles close up and in_ready_o drops only once all stages hold items.
`default_nettype none

module cubic_spline_segment_eval
  import csse_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire in_item_t  in_item_i,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output out_item_t      out_item_o,
  input  wire logic      cfg_we_i,
  input  wire logic [1:0] cfg_wdata_i
);

  kind_e               kind_q;
  logic [N_STAGES:1]   v_q;
  logic [N_STAGES:1]   en;

  // stage registers
  param_t    t1_q;
  square_t   sq1_q;
  param_t    t2_q;
  param_t    tsq2_q;
  square_t   cub2_q;
  param_t    t3_q;
  param_t    tsq3_q;
  param_t    tcub3_q;
  weight_t   w4_q [N_ROWS];
  prod_t     p5_q [N_ROWS];
  sum_t      a6_q;
  sum_t      b6_q;
  out_item_t out_q;
  coord_t    val_q [4][N_ROWS];

  param_t    t_clamp;
  param_t    tsq_d;
  param_t    tcub_d;
  weight_t   w_d [N_ROWS];
  prod_t     p_d [N_ROWS];
  sum_t      total;
  res_t      res;
  logic [R_BITS-COORD_BITS:0] res_hi;
  logic      in_range;

  // a stage moves on when it is empty or the one after it moves on
  always_comb begin
    en[N_STAGES] = !v_q[N_STAGES] || out_ready_i;
    for (int k = N_STAGES - 1; k >= 1; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign in_ready_o  = en[1];
  assign out_valid_o = v_q[N_STAGES];
  assign out_item_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q <= KIND_BEZIER;
      v_q    <= '0;
    end else begin
      if (cfg_we_i && cfg_wdata_i != KIND_UNUSED) begin
        kind_q <= kind_e'(cfg_wdata_i);
      end
      if (en[1]) begin
        v_q[1] <= in_valid_i;
      end
      for (int k = 2; k <= N_STAGES; k++) begin
        if (en[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  assign t_clamp = (in_item_i.t_param > T_ONE) ? T_ONE : in_item_i.t_param;
  assign tsq_d   = param_t'((sq1_q + SQ_HALF) >> PARAM_FRAC_BITS);
  assign tcub_d  = param_t'((cub2_q + SQ_HALF) >> PARAM_FRAC_BITS);

  always_comb begin
    weight_t c3, c2, c1, c0, wt, wt2, wt3, wone;
    wt   = weight_t'(t3_q);
    wt2  = weight_t'(tsq3_q);
    wt3  = weight_t'(tcub3_q);
    wone = weight_t'(T_ONE);
    for (int k = 0; k < N_ROWS; k++) begin
      c3     = weight_t'(BASIS_TAB[kind_q][k][0]);
      c2     = weight_t'(BASIS_TAB[kind_q][k][1]);
      c1     = weight_t'(BASIS_TAB[kind_q][k][2]);
      c0     = weight_t'(BASIS_TAB[kind_q][k][3]);
      w_d[k] = c3 * wt3 + c2 * wt2 + c1 * wt + c0 * wone;
    end
  end

  always_comb begin
    for (int k = 0; k < N_ROWS; k++) begin
      p_d[k] = prod_t'(val_q[3][k]) * prod_t'(w4_q[k]);
    end
  end

  assign total    = a6_q + b6_q;
  assign res      = res_t'(total >>> T_BITS);
  assign res_hi   = res[R_BITS-1:COORD_BITS-1];
  assign in_range = (&res_hi) || !(|res_hi);

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      t1_q        <= t_clamp;
      sq1_q       <= square_t'(t_clamp) * square_t'(t_clamp);
      val_q[0][0] <= in_item_i.start_value;
      val_q[0][1] <= in_item_i.end_value;
      val_q[0][2] <= in_item_i.first_control;
      val_q[0][3] <= in_item_i.second_control;
    end
    if (en[2]) begin
      t2_q     <= t1_q;
      tsq2_q   <= tsq_d;
      cub2_q   <= square_t'(tsq_d) * square_t'(t1_q);
      val_q[1] <= val_q[0];
    end
    if (en[3]) begin
      t3_q     <= t2_q;
      tsq3_q   <= tsq2_q;
      tcub3_q  <= tcub_d;
      val_q[2] <= val_q[1];
    end
    if (en[4]) begin
      w4_q     <= w_d;
      val_q[3] <= val_q[2];
    end
    if (en[5]) begin
      p5_q <= p_d;
    end
    if (en[6]) begin
      a6_q <= sum_t'(p5_q[0]) + sum_t'(p5_q[1]);
      b6_q <= sum_t'(p5_q[2]) + sum_t'(p5_q[3]) + ROUND_HALF;
    end
    if (en[7]) begin
      // clip to the coordinate range
      if (in_range) begin
        out_q.curve_value <= coord_t'(res);
        out_q.clipped     <= 1'b0;
      end else begin
        out_q.curve_value <= res[R_BITS-1] ? COORD_MIN : COORD_MAX;
        out_q.clipped     <= 1'b1;
      end
    end
  end

  a_accept_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> v_q[1])
    else $error("accepted item missing from first stage");

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (&v_q))
    else $error("input stalled while pipeline has a bubble");

  a_clip_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_item_o.clipped) |->
      (out_item_o.curve_value == COORD_MAX || out_item_o.curve_value == COORD_MIN))
    else $error("clipped result not at a range limit");

endmodule

`default_nettype wire

/* dv/spline_point_checker.sv */
`timescale 1ns / 100ps
// Checker for cubic_spline_segment_eval: watches both item channels and the basis
// register port, predicts every curve point and compares it with what comes out.
// Depends on csse_pkg for the item types, widths and basis codes.
module spline_point_checker
  import csse_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_ready_i,
  input  in_item_t   in_item_i,
  input  logic       out_valid_i,
  input  logic       out_ready_i,
  input  out_item_t  out_item_i,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_wdata_i,
  output int         mismatches_o,
  output int         outstanding_o
);

  localparam int     FRAC = PARAM_FRAC_BITS;
  localparam longint UNIT = longint'(1) << FRAC;

  // basis weights times two; rows begin, end, control 1, control 2;
  // columns t^3, t^2, t, 1
  localparam int WEIGHT_COEF [3][4][4] = '{
    '{ '{-2, 6, -6, 2}, '{ 2,  0, 0, 0}, '{ 6, -12, 6, 0}, '{-6,  6, 0, 0} },
    '{ '{ 4, -6, 0, 2}, '{-4,  6, 0, 0}, '{ 2,  -4, 2, 0}, '{ 2, -2, 0, 0} },
    '{ '{-1, 2, -1, 0}, '{ 3, -5, 0, 2}, '{-3,   4, 1, 0}, '{ 1, -1, 0, 0} }
  };

  kind_e     basis;
  out_item_t expected_points [$];
  int        n_bad;

  function automatic out_item_t predict_curve_point(in_item_t it, kind_e k);
    longint    tp, tsq, tcu, w, acc, pt;
    longint    pts [4];
    int        row;
    out_item_t r;
    tp = longint'(it.t_param);
    if (tp > UNIT) tp = UNIT;
    tsq = (tp * tp + UNIT / 2) >>> FRAC;
    tcu = (tsq * tp + UNIT / 2) >>> FRAC;
    pts[0] = longint'($signed(it.start_value));
    pts[1] = longint'($signed(it.end_value));
    pts[2] = longint'($signed(it.first_control));
    pts[3] = longint'($signed(it.second_control));
    acc = 0;
    for (row = 0; row < 4; row++) begin
      w = WEIGHT_COEF[int'(k)][row][0] * tcu + WEIGHT_COEF[int'(k)][row][1] * tsq
        + WEIGHT_COEF[int'(k)][row][2] * tp + WEIGHT_COEF[int'(k)][row][3] * UNIT;
      acc += pts[row] * w;
    end
    // weights carry one extra fraction bit; round half up, then clamp
    pt = (acc + UNIT) >>> (FRAC + 1);
    r.clipped = 1'b1;
    if (pt > longint'(COORD_MAX)) r.curve_value = COORD_MAX;
    else if (pt < longint'(COORD_MIN)) r.curve_value = COORD_MIN;
    else begin
      r.curve_value = coord_t'(pt);
      r.clipped     = 1'b0;
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    if (!rst_ni) begin
      basis = KIND_BEZIER;
      expected_points.delete();
      n_bad = 0;
      mismatches_o  <= 0;
      outstanding_o <= 0;
    end else begin
      if (in_valid_i && in_ready_i)
        expected_points = {expected_points, predict_curve_point(in_item_i, basis)};
      if (out_valid_i && out_ready_i) begin
        if (expected_points.size() == 0) begin
          $display("%0t: result %h arrived with none expected", $time, out_item_i);
          n_bad++;
        end else begin
          want = expected_points.pop_front();
          if (want.curve_value !== out_item_i.curve_value) begin
            $display("%0t: curve_value mismatch: expected %h, got %h",
                     $time, want.curve_value, out_item_i.curve_value);
            n_bad++;
          end
          if (want.clipped !== out_item_i.clipped) begin
            $display("%0t: clipped mismatch: expected %b, got %b",
                     $time, want.clipped, out_item_i.clipped);
            n_bad++;
          end
        end
      end
      // drop writes of the code with no basis behind it
      if (cfg_we_i && cfg_wdata_i != KIND_UNUSED) basis = kind_e'(cfg_wdata_i);
      mismatches_o  <= n_bad;
      outstanding_o <= expected_points.size();
    end
  end

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 100ps
// Testbench top for cubic_spline_segment_eval: clock, reset, basis writes, item
// stimulus with random idling on both channels, and the verdict.
// Depends on csse_pkg and spline_point_checker.
module tb_top;
  import csse_pkg::*;

  localparam int RANDOM_ITEMS = 1600;
  localparam int CYCLE_LIMIT  = 800_000;
  localparam int PIPE_DEPTH   = 7;

  logic       clk       = 1'b0;
  logic       rst_n     = 1'b0;
  logic       in_valid  = 1'b0;
  logic       in_ready;
  in_item_t   in_item   = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  out_item_t  out_item;
  logic       cfg_we    = 1'b0;
  logic [1:0] cfg_wdata = '0;
  int         mismatches;
  int         outstanding;

  bit send_calm      = 1'b0;
  int send_mode_left = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  cubic_spline_segment_eval dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_item_o  (out_item),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  spline_point_checker u_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_i    (in_ready),
    .in_item_i     (in_item),
    .out_valid_i   (out_valid),
    .out_ready_i   (out_ready),
    .out_item_i    (out_item),
    .cfg_we_i      (cfg_we),
    .cfg_wdata_i   (cfg_wdata),
    .mismatches_o  (mismatches),
    .outstanding_o (outstanding)
  );

  // mostly short pauses, now and then a long one
  function automatic int pause_len();
    int r;
    r = $urandom_range(0, 19);
    if (r < 14) return $urandom_range(1, 3);
    if (r < 19) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic in_item_t make_item(param_t t, coord_t a, coord_t b, coord_t c,
                                         coord_t d);
    in_item_t it;
    it.t_param        = t;
    it.start_value    = a;
    it.end_value      = b;
    it.first_control  = c;
    it.second_control = d;
    return it;
  endfunction

  function automatic coord_t rand_coord();
    case ($urandom_range(0, 9))
      0: return COORD_MAX;
      1: return COORD_MIN;
      2, 3: return coord_t'($urandom);
      default: return coord_t'($signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000);
    endcase
  endfunction

  function automatic in_item_t rand_item();
    param_t t;
    case ($urandom_range(0, 15))
      0: t = '0;
      1: t = T_ONE;
      2: t = param_t'($urandom_range(T_ONE + 1, (1 << T_BITS) - 1));
      default: t = param_t'($urandom_range(0, T_ONE));
    endcase
    return make_item(t, rand_coord(), rand_coord(), rand_coord(), rand_coord());
  endfunction

  task automatic send_item(input in_item_t it);
    int gap;
    gap = 0;
    if (send_mode_left == 0) begin
      send_calm      = ($urandom_range(0, 3) == 0);
      send_mode_left = $urandom_range(20, 200);
    end
    send_mode_left--;
    if (!send_calm && $urandom_range(0, 2) == 0) gap = pause_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (!in_ready);
  endtask

  // stop offering and wait for every outstanding point to come back
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic write_kind(input logic [1:0] code);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= code;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic run_directed();
    send_item(make_item('0, COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN));
    send_item(make_item(T_ONE, COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX));
    // parameters above one clamp to exactly one
    send_item(make_item('1, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX));
    send_item(make_item(param_t'(T_ONE + 1), COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN));
    send_item(make_item(T_ONE >> 1, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX));
    send_item(make_item(param_t'(1), coord_t'(1), coord_t'(-1), '0, '0));
    send_item(make_item(param_t'(T_ONE - 1), 32'sh0001_0000, 32'sh0003_0000,
                        -32'sh0002_8000, 32'sh0000_8000));
  endtask

  initial begin
    int sent;
    int seg;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    run_directed();
    drain();
    write_kind(KIND_HERMITE);
    write_kind(KIND_UNUSED);
    run_directed();
    drain();
    write_kind(KIND_CATMULL_ROM);
    run_directed();
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      drain();
      if (sent == 0) write_kind(KIND_BEZIER);
      else write_kind(2'($urandom_range(0, 3)));
      seg = $urandom_range(50, 250);
      repeat (seg) send_item(rand_item());
      sent += seg;
    end
    drain();
    repeat (2 * PIPE_DEPTH) @(posedge clk);
    if (mismatches == 0 && outstanding == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // receiver: random stalls, calm stretches and two long hold-offs
  initial begin
    int  stall_left;
    int  mode_left;
    int  next_hold;
    int  taken;
    bit  calm;
    stall_left = 0;
    mode_left  = 0;
    next_hold  = 100;
    taken      = 0;
    calm       = 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) taken++;
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else if (taken >= next_hold) begin
        // hold off long enough for the pipeline to back up into the input
        out_ready  <= 1'b0;
        stall_left = 299;
        next_hold  += 900;
      end else begin
        if (mode_left == 0) begin
          calm      = ($urandom_range(0, 3) == 0);
          mode_left = $urandom_range(50, 300);
        end
        mode_left--;
        if (!calm && $urandom_range(0, 3) == 0) begin
          out_ready  <= 1'b0;
          stall_left = pause_len() - 1;
        end else begin
          out_ready <= 1'b1;
        end
      end
    end
  end

  initial begin
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("%0t: timeout with %0d points still expected", $time, outstanding);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
